// ===== hw/rtl/mpht_pkg.sv =====
package mpht_pkg;

  localparam int KEY_WIDTH   = 32;
  localparam int CMD_WIDTH   = 2;
  localparam int CFG_WIDTH   = 3;
  localparam int ROWS_RESET  = 4;

  typedef enum logic [1:0] {
    CMD_GET,
    CMD_SEARCH,
    CMD_INSERT,
    CMD_REMOVE
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FOUND,
    ST_CLAIMED,
    ST_MISS,
    ST_BAD_KEY
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_ISSUE,
    B_CHECK
  } back_state_t;

  function automatic int mod_const(int n, int d);
    int rem;
    rem = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 1) | ((n >> i) & 1);
      if (rem >= d) rem = rem - d;
    end
    return rem;
  endfunction

  function automatic bit is_prime(int n);
    bit ok;
    ok = 1'b1;
    if (n < 2) ok = 1'b0;
    for (int d = 2; d * d <= n; d++) begin
      if (mod_const(n, d) == 0) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic int row_prime(int row_len, int idx);
    int found;
    int prev;
    found = 0;
    prev  = 2;
    for (int cand = row_len; cand >= 2; cand--) begin
      if (is_prime(cand)) begin
        if (found == idx) return cand;
        prev  = cand;
        found = found + 1;
      end
    end
    return prev;
  endfunction

  function automatic int ceil_log2(int n);
    int l;
    l = 0;
    while ((1 << l) < n) l++;
    return l;
  endfunction

  function automatic longint unsigned div_const(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((n >> i) & 64'd1);
      q   = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic logic [KEY_WIDTH:0] recip_const(int p);
    longint unsigned num;
    longint unsigned den;
    den = longint'(p);
    num = 64'd1 << (KEY_WIDTH + ceil_log2(p));
    return (KEY_WIDTH+1)'(div_const(num + den - 64'd1, den));
  endfunction

endpackage

// ===== hw/rtl/mpht_ram.sv =====
module mpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mpht_queue.sv =====
module mpht_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;

  assign full  = (count == CNW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

endmodule

// ===== hw/rtl/mpht_front.sv =====
module mpht_front import mpht_pkg::*; #(
  parameter int ROWS = 4,
  parameter int ROW_LEN = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int SW = $clog2(ROW_LEN),
  localparam int EW = CMD_WIDTH + 1 + KEY_WIDTH + DATA_WIDTH + ROWS * SW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [CMD_WIDTH-1:0] command,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [31:0]          data,
  output logic                 busy,
  output logic                 q_push,
  output logic [EW-1:0]        q_entry,
  input  logic                 q_full
);

  front_state_t          state, state_next;
  logic [CMD_WIDTH-1:0]  cmd;
  logic                  bad;
  logic [KEY_WIDTH-1:0]  kval;
  logic [DATA_WIDTH-1:0] dval;
  logic                  step;
  logic [KEY_WIDTH-1:0]  quo [ROWS];
  logic [KEY_WIDTH-1:0]  quo_next [ROWS];
  logic [SW-1:0]         rem [ROWS];
  logic [SW-1:0]         rem_next [ROWS];
  logic [ROWS*SW-1:0]    slots_flat;

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    localparam int P = row_prime(ROW_LEN, r);
    localparam int SH = KEY_WIDTH + ceil_log2(P);
    localparam logic [KEY_WIDTH:0] M = recip_const(P);
    logic [2*KEY_WIDTH:0] prod;
    assign prod = (2*KEY_WIDTH+1)'(kval) * (2*KEY_WIDTH+1)'(M);
    assign quo_next[r] = KEY_WIDTH'(prod >> SH);
    assign rem_next[r] = kval[SW-1:0] - SW'(quo[r][SW-1:0] * SW'(P));
    assign slots_flat[r*SW +: SW] = rem[r];
  end

  assign q_entry = {cmd, bad, kval, dval, slots_flat};
  assign busy    = (state != F_IDLE);

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (take) state_next = (key == '0) ? F_PUSH : F_CALC;
      end
      F_CALC: begin
        if (step == 1'b1) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && take) begin
      cmd    <= command;
      bad    <= (key == '0);
      kval   <= key;
      dval   <= DATA_WIDTH'(data);
      step   <= 1'b0;
    end else if (state == F_CALC) begin
      if (step == 1'b0) begin
        for (int r = 0; r < ROWS; r++) quo[r] <= quo_next[r];
      end else begin
        for (int r = 0; r < ROWS; r++) rem[r] <= rem_next[r];
      end
      step <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/mpht_back.sv =====
module mpht_back import mpht_pkg::*; #(
  parameter int ROWS = 4,
  parameter int ROW_LEN = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int SW = $clog2(ROW_LEN),
  localparam int EW = CMD_WIDTH + 1 + KEY_WIDTH + DATA_WIDTH + ROWS * SW,
  localparam int CW = $clog2(ROWS + 1),
  localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CW-1:0]         nrows,
  input  logic                  q_empty,
  input  logic [EW-1:0]         q_head,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  done,
  output logic [1:0]            status,
  output logic                  is_new,
  output logic [RIW-1:0]        row_index,
  output logic [SW-1:0]         slot_index,
  output logic [DATA_WIDTH-1:0] stored_data
);

  localparam int DEPTH = ROWS * ROW_LEN;
  localparam int AW = $clog2(DEPTH);
  localparam int DATA_LO = ROWS * SW;
  localparam int KEY_LO = DATA_LO + DATA_WIDTH;
  localparam int BAD_POS = KEY_LO + KEY_WIDTH;
  localparam int CMD_LO = BAD_POS + 1;

  back_state_t           state, state_next;
  cmd_t                  cmd;
  logic [KEY_WIDTH-1:0]  kval;
  logic [DATA_WIDTH-1:0] dval;
  logic [SW-1:0]         slots [ROWS];
  logic [CW-1:0]         row;
  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         addr;
  logic [KEY_WIDTH-1:0]  rkey;
  logic [DATA_WIDTH-1:0] rdat;

  logic                  key_we;
  logic [AW-1:0]         key_waddr;
  logic [KEY_WIDTH-1:0]  key_wdata;
  logic                  dat_we;

  logic                  emit;
  status_t               emit_status;
  logic                  emit_new;
  logic                  emit_hit;
  logic [DATA_WIDTH-1:0] emit_data;
  logic                  load;
  logic                  row_step;

  assign addr = AW'(row[RIW-1:0]) * AW'(ROW_LEN) + AW'(slots[row[RIW-1:0]]);
  assign clearing = (state == B_CLEAR);

  mpht_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (addr),
    .rdata (rkey)
  );

  mpht_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (addr),
    .wdata (dval),
    .raddr (addr),
    .rdata (rdat)
  );

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    load        = 1'b0;
    row_step    = 1'b0;
    key_we      = 1'b0;
    key_waddr   = addr;
    key_wdata   = kval;
    dat_we      = 1'b0;
    emit        = 1'b0;
    emit_status = ST_MISS;
    emit_new    = 1'b0;
    emit_hit    = 1'b0;
    emit_data   = '0;
    unique case (state)
      B_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_addr;
        key_wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          load  = 1'b1;
          if (q_head[BAD_POS]) begin
            emit        = 1'b1;
            emit_status = ST_BAD_KEY;
          end else if (nrows == '0) begin
            emit = 1'b1;
          end else begin
            state_next = B_ISSUE;
          end
        end
      end
      B_ISSUE: state_next = B_CHECK;
      B_CHECK: begin
        unique case (cmd)
          CMD_GET: begin
            if (rkey == '0) begin
              key_we      = 1'b1;
              dat_we      = 1'b1;
              emit_hit    = 1'b1;
              emit_status = ST_CLAIMED;
              emit_new    = 1'b1;
              emit_data   = dval;
            end else if (rkey == kval) begin
              emit_hit    = 1'b1;
              emit_status = ST_FOUND;
              emit_data   = rdat;
            end
          end
          CMD_SEARCH: begin
            if (rkey == kval) begin
              emit_hit    = 1'b1;
              emit_status = ST_FOUND;
              emit_data   = rdat;
            end
          end
          CMD_INSERT: begin
            if (rkey == '0) begin
              key_we      = 1'b1;
              dat_we      = 1'b1;
              emit_hit    = 1'b1;
              emit_status = ST_FOUND;
              emit_data   = dval;
            end
          end
          CMD_REMOVE: begin
            if (rkey == kval) begin
              key_we      = 1'b1;
              key_wdata   = '0;
              emit_hit    = 1'b1;
              emit_status = ST_FOUND;
              emit_data   = rdat;
            end
          end
          default: emit_hit = 1'b0;
        endcase
        if (emit_hit) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end else if (CW'(row + 1'b1) == nrows) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end else begin
          row_step   = 1'b1;
          state_next = B_ISSUE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (state == B_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd  <= cmd_t'(q_head[CMD_LO +: CMD_WIDTH]);
      kval <= q_head[KEY_LO +: KEY_WIDTH];
      dval <= q_head[DATA_LO +: DATA_WIDTH];
      for (int r = 0; r < ROWS; r++) slots[r] <= q_head[r*SW +: SW];
      row  <= '0;
    end else if (row_step) begin
      row <= row + 1'b1;
    end
    if (emit) begin
      status      <= emit_status;
      is_new      <= emit_new;
      row_index   <= emit_hit ? row[RIW-1:0] : '0;
      slot_index  <= emit_hit ? slots[row[RIW-1:0]] : '0;
      stored_data <= emit_data;
    end
  end

endmodule

// ===== hw/rtl/multilevel_prime_hash_table.sv =====
// Multi-row hash table, row r indexed by the key modulo the r-th largest prime
// not above ROW_LEN. Issue a command with start while busy is low; the result
// appears for one cycle with done and must be taken then, as the receiver
// cannot stall. After reset every address of the key store is swept to zero
// with busy high. The front takes a command in, forms the quotient for all
// rows at once by a reciprocal multiplication, then the remainder, and
// pushes the entry into a two-entry queue, waiting while the queue is full;
// a key of zero skips the arithmetic. The back pops an entry and probes one
// row after another, an issue state then a check state per row, through the
// registered key memory, until a hit or the last row in use. The front
// takes the next command once its entry is pushed, while the back still
// probes. rows_in_use may be written only while no command is outstanding.
module multilevel_prime_hash_table import mpht_pkg::*; #(
  parameter int ROWS = 4,
  parameter int ROW_LEN = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int SW = $clog2(ROW_LEN),
  localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_WIDTH-1:0]  command,
  input  logic [KEY_WIDTH-1:0]  key,
  input  logic [31:0]           data,
  output logic                  done,
  output logic [1:0]            status,
  output logic                  is_new,
  output logic [RIW-1:0]        row_index,
  output logic [SW-1:0]         slot_index,
  output logic [DATA_WIDTH-1:0] stored_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_WIDTH-1:0]  cfg_data
);

  localparam int EW = CMD_WIDTH + 1 + KEY_WIDTH + DATA_WIDTH + ROWS * SW;
  localparam int CW = $clog2(ROWS + 1);

  logic [CFG_WIDTH-1:0] rows_in_use;
  logic [CW-1:0]        nrows;
  logic                 front_busy;
  logic                 clearing;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  logic [EW-1:0]        q_entry;
  logic [EW-1:0]        q_head;

  assign cfg_ready = 1'b1;
  assign busy      = front_busy | clearing;
  assign nrows     = (int'(rows_in_use) > ROWS) ? CW'(ROWS) : CW'(rows_in_use);

  always_ff @(posedge clk) begin
    if (rst) rows_in_use <= CFG_WIDTH'(ROWS_RESET);
    else if (cfg_valid && cfg_ready) rows_in_use <= cfg_data;
  end

  mpht_front #(.ROWS(ROWS), .ROW_LEN(ROW_LEN), .DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (start && !busy),
    .command (command),
    .key     (key),
    .data    (data),
    .busy    (front_busy),
    .q_push  (q_push),
    .q_entry (q_entry),
    .q_full  (q_full)
  );

  mpht_queue #(.WIDTH(EW), .DEPTH(2)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  mpht_back #(.ROWS(ROWS), .ROW_LEN(ROW_LEN), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .nrows       (nrows),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .done        (done),
    .status      (status),
    .is_new      (is_new),
    .row_index   (row_index),
    .slot_index  (slot_index),
    .stored_data (stored_data)
  );

endmodule
